// ===== sv/dwi_pkg.sv =====
// ----------------------------------------------------------------------------
// dwi_pkg
// Shared types and constants for the DAWG word index lookup core.
// ----------------------------------------------------------------------------
package dwi_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [31:0] ACCEPT_BIT = 32'h0080_0000;
  localparam logic [31:0] END_BIT    = 32'h0040_0000;
  localparam logic [31:0] ARC_MASK   = 32'h003F_FFFF;
  localparam int unsigned TILE_SHIFT = 24;
  localparam logic [8:0]  PASS_LIMIT = 9'd256;

  localparam logic RK_BUILD = 1'b0;
  localparam logic RK_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_B_RD,
    ST_B_CH,
    ST_B_SUM,
    ST_Q_ROOT,
    ST_Q_ROOTW,
    ST_Q_CHK,
    ST_Q_CMP,
    ST_Q_ADD
  } state_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

endpackage

// ===== sv/dwi_alu.sv =====
// ----------------------------------------------------------------------------
// dwi_alu
// Shared 32-bit add/subtract unit used by build and query steps.
// ----------------------------------------------------------------------------
module dwi_alu (
  input  dwi_pkg::alu_req_t req_i,
  output logic [31:0]       sum_o
);

  assign sum_o = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);

endmodule

// ===== sv/dawg_word_index_lookup_core.sv =====
// ----------------------------------------------------------------------------
// dawg_word_index_lookup_core
// Packed DAWG node table with subtree count build and word rank lookup.
// ----------------------------------------------------------------------------
// Load: busy stays low, the word is written at the accept edge; a new beat may follow.
// Build: clear N counts, then B_RD, B_CH, B_SUM per node in each pass over N active
//   nodes, up to 256 passes (empty table: B_SUM only); the result strobe follows.
// Query letter: Q_CHK, Q_CMP, Q_ADD per skipped sibling; Q_ROOT(W) on a first letter.
// Reset clears control and query state; table contents stay undefined.
// The receiver cannot stall: each result shows for one cycle.
module dawg_word_index_lookup_core #(
  parameter int unsigned MAX_NODES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [11:0] node_address_i,
  input  logic [31:0] node_word_i,
  input  logic [7:0]  letter_i,
  input  logic        last_letter_i,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  output logic        result_valid_o,
  output logic        result_kind_o,
  output logic        found_o,
  output logic [31:0] word_rank_o,
  output logic [15:0] pass_count_o
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned NW = AW + 1;
  localparam logic [22:0] MAXN23 = 23'(MAX_NODES);

  dwi_pkg::state_e state_q, state_d;

  logic [12:0]   node_count_q;
  logic [NW-1:0] nact;
  logic [22:0]   n23;

  logic [31:0] node_mem [MAX_NODES];
  logic [31:0] cnt_mem  [MAX_NODES];

  logic [AW-1:0] node_ra;
  logic [AW-1:0] cnt_ra, cnt_rb, cnt_wa;
  logic          cnt_we;
  logic [31:0]   cnt_wd;
  logic [31:0]   node_rd_q, cnt_a_q, cnt_b_q;

  logic [NW-1:0] i_q, i_d;
  logic [8:0]    passes_q, passes_d;
  logic          changed_q, changed_d;
  logic          sib_ok_q, sib_ok_d;
  logic          ch_ok_q, ch_ok_d;
  logic [31:0]   acc_q, acc_d;
  logic [31:0]   old_q, old_d;

  logic [21:0]   walk_q, walk_d;
  logic [31:0]   rank_q, rank_d;
  logic          started_q, started_d;
  logic          failed_q, failed_d;
  logic [7:0]    letter_q, letter_d;
  logic          last_q, last_d;

  logic          rv_q, rv_d;
  logic          rk_q, rk_d;
  logic          fd_q, fd_d;
  logic [31:0]   wr_q, wr_d;
  logic [15:0]   pc_q, pc_d;

  dwi_pkg::alu_req_t alu_req;
  logic [31:0]       alu_sum;

  logic          accept;
  logic [21:0]   arc;
  logic [22:0]   walk_nxt23;
  logic [22:0]   i_nxt23;
  logic [31:0]   sib_val, ch_val;

  dwi_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  assign n23    = {10'd0, node_count_q};
  assign nact   = (n23 >= MAXN23) ? NW'(MAX_NODES) : NW'(node_count_q);
  assign accept = start_i && (state_q == dwi_pkg::ST_IDLE);
  assign busy_o = (state_q != dwi_pkg::ST_IDLE);
  assign arc    = node_rd_q[21:0];
  assign walk_nxt23 = {1'b0, walk_q} + 23'd1;
  assign i_nxt23    = 23'(i_q) + 23'd1;
  assign sib_val = sib_ok_q ? cnt_b_q : 32'd0;
  assign ch_val  = ch_ok_q ? cnt_a_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '0;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  // node table: load port writes, one read port for the build and query walks
  always_ff @(posedge clk_i) begin
    if (accept && opcode_i == dwi_pkg::OP_LOAD && 23'(node_address_i) < MAXN23) begin
      node_mem[node_address_i[AW-1:0]] <= node_word_i;
    end
    node_rd_q <= node_mem[node_ra];
  end

  // count store: one write, two reads
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_a_q <= cnt_mem[cnt_ra];
    cnt_b_q <= cnt_mem[cnt_rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dwi_pkg::ST_IDLE;
      walk_q    <= '0;
      rank_q    <= '0;
      started_q <= 1'b0;
      failed_q  <= 1'b0;
      rv_q      <= 1'b0;
      i_q       <= '0;
      passes_q  <= '0;
      changed_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      walk_q    <= walk_d;
      rank_q    <= rank_d;
      started_q <= started_d;
      failed_q  <= failed_d;
      rv_q      <= rv_d;
      i_q       <= i_d;
      passes_q  <= passes_d;
      changed_q <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sib_ok_q <= sib_ok_d;
    ch_ok_q  <= ch_ok_d;
    acc_q    <= acc_d;
    old_q    <= old_d;
    letter_q <= letter_d;
    last_q   <= last_d;
    rk_q     <= rk_d;
    fd_q     <= fd_d;
    wr_q     <= wr_d;
    pc_q     <= pc_d;
  end

  always_comb begin
    logic [31:0] cnt_new;
    state_d   = state_q;
    walk_d    = walk_q;
    rank_d    = rank_q;
    started_d = started_q;
    failed_d  = failed_q;
    i_d       = i_q;
    passes_d  = passes_q;
    changed_d = changed_q;
    sib_ok_d  = sib_ok_q;
    ch_ok_d   = ch_ok_q;
    acc_d     = acc_q;
    old_d     = old_q;
    letter_d  = letter_q;
    last_d    = last_q;
    rv_d      = 1'b0;
    rk_d      = rk_q;
    fd_d      = fd_q;
    wr_d      = wr_q;
    pc_d      = pc_q;
    node_ra   = i_q[AW-1:0];
    cnt_ra    = i_q[AW-1:0];
    cnt_rb    = i_nxt23[AW-1:0];
    cnt_we    = 1'b0;
    cnt_wa    = i_q[AW-1:0];
    cnt_wd    = '0;
    alu_req   = '{a: rank_q, b: 32'd1, sub: 1'b0};
    cnt_new   = alu_sum;

    unique case (state_q)
      dwi_pkg::ST_IDLE: begin
        if (accept) begin
          letter_d = letter_i;
          last_d   = last_letter_i;
          case (opcode_i)
            dwi_pkg::OP_BUILD: begin
              i_d      = '0;
              passes_d = 9'd1;
              state_d  = (nact == '0) ? dwi_pkg::ST_B_SUM : dwi_pkg::ST_CLR;
            end
            dwi_pkg::OP_QUERY: begin
              state_d = started_q ? dwi_pkg::ST_Q_CHK : dwi_pkg::ST_Q_ROOT;
            end
            default: ;
          endcase
        end
      end

      dwi_pkg::ST_CLR: begin
        cnt_we = 1'b1;
        cnt_wa = i_q[AW-1:0];
        if (i_nxt23 == 23'(nact)) begin
          i_d       = NW'(nact - NW'(1));
          changed_d = 1'b0;
          state_d   = dwi_pkg::ST_B_RD;
        end else begin
          i_d = i_q + NW'(1);
        end
      end

      dwi_pkg::ST_B_RD: begin
        // fetch node, its old count and its right neighbor's count
        sib_ok_d = (i_nxt23 < 23'(nact));
        state_d  = dwi_pkg::ST_B_CH;
      end

      dwi_pkg::ST_B_CH: begin
        alu_req = '{a: {31'd0, |(node_rd_q & dwi_pkg::ACCEPT_BIT)},
                    b: (|(node_rd_q & dwi_pkg::END_BIT)) ? 32'd0 : sib_val,
                    sub: 1'b0};
        acc_d   = alu_sum;
        old_d   = cnt_a_q;
        cnt_ra  = arc[AW-1:0];
        ch_ok_d = (arc != '0) && ({1'b0, arc} < 23'(nact));
        state_d = dwi_pkg::ST_B_SUM;
      end

      dwi_pkg::ST_B_SUM: begin
        if (nact == '0) begin
          // empty table: one pass that changes nothing
          rv_d    = 1'b1;
          rk_d    = dwi_pkg::RK_BUILD;
          fd_d    = 1'b0;
          wr_d    = '0;
          pc_d    = 16'(passes_q);
          state_d = dwi_pkg::ST_IDLE;
        end else begin
          alu_req = '{a: acc_q, b: ch_val, sub: 1'b0};
          cnt_new = alu_sum;
          if (cnt_new != old_q) begin
            cnt_we    = 1'b1;
            cnt_wa    = i_q[AW-1:0];
            cnt_wd    = cnt_new;
            changed_d = 1'b1;
          end
          if (i_q == '0) begin
            if ((changed_d) && (passes_q < dwi_pkg::PASS_LIMIT)) begin
              passes_d  = passes_q + 9'd1;
              changed_d = 1'b0;
              i_d       = NW'(nact - NW'(1));
              state_d   = dwi_pkg::ST_B_RD;
            end else begin
              rv_d    = 1'b1;
              rk_d    = dwi_pkg::RK_BUILD;
              fd_d    = 1'b0;
              wr_d    = '0;
              pc_d    = 16'(passes_q);
              state_d = dwi_pkg::ST_IDLE;
            end
          end else begin
            i_d     = i_q - NW'(1);
            state_d = dwi_pkg::ST_B_RD;
          end
        end
      end

      dwi_pkg::ST_Q_ROOT: begin
        node_ra = '0;
        state_d = dwi_pkg::ST_Q_ROOTW;
      end

      dwi_pkg::ST_Q_ROOTW: begin
        walk_d    = arc;
        rank_d    = '0;
        started_d = 1'b1;
        failed_d  = 1'b0;
        state_d   = dwi_pkg::ST_Q_CHK;
      end

      dwi_pkg::ST_Q_CHK: begin
        node_ra  = walk_q[AW-1:0];
        cnt_ra   = walk_q[AW-1:0];
        cnt_rb   = walk_nxt23[AW-1:0];
        sib_ok_d = (walk_nxt23 < 23'(nact));
        if (failed_q || walk_q == '0 || {1'b0, walk_q} >= 23'(nact)) begin
          failed_d = 1'b1;
          state_d  = dwi_pkg::ST_IDLE;
          if (last_q) begin
            rv_d = 1'b1; rk_d = dwi_pkg::RK_QUERY; fd_d = 1'b0;
            wr_d = '0;   pc_d = '0;
            walk_d = '0; rank_d = '0; started_d = 1'b0; failed_d = 1'b0;
          end
        end else begin
          state_d = dwi_pkg::ST_Q_CMP;
        end
      end

      dwi_pkg::ST_Q_CMP: begin
        if (node_rd_q[31:dwi_pkg::TILE_SHIFT] == letter_q) begin
          state_d = dwi_pkg::ST_IDLE;
          if (last_q) begin
            rv_d = 1'b1; rk_d = dwi_pkg::RK_QUERY; fd_d = 1'b1;
            wr_d = rank_q; pc_d = '0;
            walk_d = '0; rank_d = '0; started_d = 1'b0; failed_d = 1'b0;
          end else begin
            alu_req = '{a: rank_q, b: 32'd1, sub: 1'b0};
            rank_d  = alu_sum;
            walk_d  = arc;
          end
        end else if (|(node_rd_q & dwi_pkg::END_BIT)) begin
          failed_d = 1'b1;
          state_d  = dwi_pkg::ST_IDLE;
          if (last_q) begin
            rv_d = 1'b1; rk_d = dwi_pkg::RK_QUERY; fd_d = 1'b0;
            wr_d = '0;   pc_d = '0;
            walk_d = '0; rank_d = '0; started_d = 1'b0; failed_d = 1'b0;
          end
        end else begin
          // skipped sibling: its own subtree is its count minus the right neighbor's
          alu_req = '{a: cnt_a_q, b: sib_val, sub: 1'b1};
          acc_d   = alu_sum;
          state_d = dwi_pkg::ST_Q_ADD;
        end
      end

      dwi_pkg::ST_Q_ADD: begin
        alu_req = '{a: rank_q, b: acc_q, sub: 1'b0};
        rank_d  = alu_sum;
        walk_d  = walk_nxt23[21:0];
        state_d = dwi_pkg::ST_Q_CHK;
      end

      default: state_d = dwi_pkg::ST_IDLE;
    endcase
  end

  assign result_valid_o = rv_q;
  assign result_kind_o  = rk_q;
  assign found_o        = fd_q;
  assign word_rank_o    = wr_q;
  assign pass_count_o   = pc_q;

  a_res_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> $past(state_q != dwi_pkg::ST_IDLE))
    else $error("result strobe without preceding work");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    passes_q <= dwi_pkg::PASS_LIMIT)
    else $error("pass counter beyond limit");

  a_miss_zero_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && !fd_q) |-> (wr_q == '0))
    else $error("rank nonzero on miss or build result");

  a_answer_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && rk_q == dwi_pkg::RK_QUERY) |-> (!started_q && !failed_q))
    else $error("query state left after answer");

endmodule

// ===== tb/dawg_word_index_lookup_core_test.sv =====
// ----------------------------------------------------------------------------
// dawg_word_index_lookup_core_test
// Self-checking bench for the DAWG word rank core: loads node tables of many
// sizes, builds subtree counts, ranks walked and broken words, and compares
// every result beat against a behavioral rank predictor.
// ----------------------------------------------------------------------------
module dawg_word_index_lookup_core_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned TABLE_DEPTH = 4096;

  typedef struct {
    logic        kind;
    logic        found;
    logic [31:0] rank;
    logic [15:0] passes;
  } answer_t;

  class rank_board;
    logic [31:0] node_tab[TABLE_DEPTH];
    logic [31:0] cnt_tab[TABLE_DEPTH];
    logic [31:0] walk_at;
    logic [31:0] rank_acc;
    bit          in_word;
    bit          word_dead;
    logic [12:0] node_count;
    answer_t     answers[$];
    int          errors;

    function void clear_word();
      walk_at = 0;
      rank_acc = 0;
      in_word = 0;
      word_dead = 0;
    endfunction

    function int unsigned active();
      return (node_count > TABLE_DEPTH) ? TABLE_DEPTH : node_count;
    endfunction

    function logic [31:0] cnt_at(logic [31:0] idx, int unsigned n);
      return (idx < n) ? cnt_tab[idx] : 32'd0;
    endfunction

    function int unsigned build_counts();
      int unsigned n;
      int unsigned passes;
      bit          changed;
      logic [31:0] node;
      logic [31:0] cnt;
      n = active();
      passes = 0;
      changed = 1;
      foreach (cnt_tab[i]) cnt_tab[i] = 0;
      while (changed && passes < dwi_pkg::PASS_LIMIT) begin
        changed = 0;
        passes++;
        for (int i = int'(n) - 1; i >= 0; i--) begin
          node = node_tab[i];
          cnt = (node & dwi_pkg::ACCEPT_BIT) ? 32'd1 : 32'd0;
          if ((node & dwi_pkg::ARC_MASK) != 0) cnt += cnt_at(node & dwi_pkg::ARC_MASK, n);
          if (!(node & dwi_pkg::END_BIT)) cnt += cnt_at(32'(i + 1), n);
          if (cnt_tab[i] != cnt) begin
            cnt_tab[i] = cnt;
            changed = 1;
          end
        end
      end
      return passes;
    endfunction

    // Walk one sibling list; true when the final letter matches.
    function bit walk_letter(logic [7:0] letter, bit last);
      int unsigned n;
      logic [31:0] w;
      logic [31:0] r;
      logic [31:0] node;
      n = active();
      w = walk_at;
      r = rank_acc;
      while (1) begin
        if (w == 0 || w >= n) begin
          word_dead = 1;
          return 0;
        end
        node = node_tab[w];
        if (node[31:24] == letter) break;
        if (node & dwi_pkg::END_BIT) begin
          word_dead = 1;
          return 0;
        end
        r += cnt_tab[w] - cnt_at(w + 1, n);
        w++;
      end
      rank_acc = r;
      if (last) return 1;
      rank_acc = r + 1;
      walk_at = node_tab[w] & dwi_pkg::ARC_MASK;
      return 0;
    endfunction

    function void note(logic [1:0] op, logic [11:0] addr, logic [31:0] word,
                       logic [7:0] letter, bit last);
      answer_t a;
      bit      hit;
      int unsigned p;
      case (op)
        dwi_pkg::OP_LOAD: node_tab[addr] = word;
        dwi_pkg::OP_BUILD: begin
          p = build_counts();
          a.kind = dwi_pkg::RK_BUILD;
          a.found = 0;
          a.rank = 0;
          a.passes = p[15:0];
          answers.push_back(a);
        end
        dwi_pkg::OP_QUERY: begin
          hit = 0;
          if (!in_word) begin
            in_word = 1;
            word_dead = 0;
            rank_acc = 0;
            walk_at = node_tab[0] & dwi_pkg::ARC_MASK;
          end
          if (!word_dead) hit = walk_letter(letter, last);
          if (last) begin
            a.kind = dwi_pkg::RK_QUERY;
            a.found = hit;
            a.rank = hit ? rank_acc : 32'd0;
            a.passes = 0;
            answers.push_back(a);
            clear_word();
          end
        end
        default: ;
      endcase
    endfunction

    function void check(logic kind, logic found, logic [31:0] rank, logic [15:0] passes);
      answer_t a;
      if (answers.size() == 0) begin
        $error("unexpected result beat kind=%0d rank=%0d", kind, rank);
        errors++;
        return;
      end
      a = answers.pop_front();
      if (kind !== a.kind) begin
        $error("result_kind: expected %0d, got %0d", a.kind, kind);
        errors++;
      end
      if (found !== a.found) begin
        $error("found: expected %0d, got %0d", a.found, found);
        errors++;
      end
      if (rank !== a.rank) begin
        $error("word_rank: expected %0d, got %0d", a.rank, rank);
        errors++;
      end
      if (passes !== a.passes) begin
        $error("pass_count: expected %0d, got %0d", a.passes, passes);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        busy_o;
  logic [1:0]  opcode_i = dwi_pkg::OP_LOAD;
  logic [11:0] node_address_i = 0;
  logic [31:0] node_word_i = 0;
  logic [7:0]  letter_i = 0;
  logic        last_letter_i = 0;
  logic        cfg_we_i = 0;
  logic [12:0] cfg_wdata_i = 0;
  logic        result_valid_o;
  logic        result_kind_o;
  logic        found_o;
  logic [31:0] word_rank_o;
  logic [15:0] pass_count_o;

  rank_board board = new();
  bit        idle_on = 1;
  int        rand_items = 0;

  dawg_word_index_lookup_core u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .node_address_i, .node_word_i,
    .letter_i, .last_letter_i, .cfg_we_i, .cfg_wdata_i, .result_valid_o,
    .result_kind_o, .found_o, .word_rank_o, .pass_count_o
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      board.check(result_kind_o, found_o, word_rank_o, pass_count_o);
  end

  // Every accepted beat counts toward the item budget.
  task automatic send(logic [1:0] op, logic [11:0] addr, logic [31:0] word,
                      logic [7:0] letter, bit last);
    if (idle_on && $urandom_range(99) < 16) begin
      @(negedge clk_i);
      start_i = 0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i = 1;
    opcode_i = op;
    node_address_i = addr;
    node_word_i = word;
    letter_i = letter;
    last_letter_i = last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note(op, addr, word, letter, last);
    rand_items++;
  endtask

  // Drain all answers and let any silent letter finish before a register write.
  task automatic set_nodes(logic [12:0] value);
    @(negedge clk_i);
    start_i = 0;
    while (board.answers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    cfg_we_i = 1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 0;
    board.node_count = value;
  endtask

  // Arcs mostly point forward so builds converge; random ones may point back or off the table.
  function automatic logic [31:0] gen_node(int unsigned idx, int unsigned n);
    logic [31:0] word;
    word = $urandom;
    word[23] = ($urandom_range(99) < 60);
    word[22] = ($urandom_range(99) < 35) || (idx + 1 >= n);
    case ($urandom_range(9))
      0, 1, 2: word[21:0] = 0;
      3: word[21:0] = 22'($urandom);
      default: word[21:0] = (idx + 1 < n) ? 22'($urandom_range(n - 1, idx + 1)) : 22'd0;
    endcase
    return word;
  endfunction

  task automatic load_table(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send(dwi_pkg::OP_LOAD, 12'(i), gen_node(i, n), 0, 0);
  endtask

  task automatic send_word();
    int unsigned n;
    int unsigned len;
    logic [31:0] w;
    logic [7:0]  letter;
    n = board.active();
    len = $urandom_range(6, 1);
    w = board.node_tab[0] & dwi_pkg::ARC_MASK;
    for (int unsigned k = 0; k < len; k++) begin
      letter = 8'($urandom);
      if (w != 0 && w < n) begin
        repeat ($urandom_range(3)) begin
          if (!(board.node_tab[w] & dwi_pkg::END_BIT) && w + 1 < n) w++;
        end
        if ($urandom_range(9) != 0) letter = board.node_tab[w][31:24];
        w = board.node_tab[w] & dwi_pkg::ARC_MASK;
      end
      send(dwi_pkg::OP_QUERY, 0, 0, letter, k == len - 1);
    end
  endtask

  task automatic run_phase(int unsigned n, int unsigned beats);
    int unsigned sel;
    set_nodes(13'(n));
    load_table(n);
    send(dwi_pkg::OP_BUILD, 0, 0, 0, 0);
    repeat (beats) begin
      sel = $urandom_range(99);
      if (sel < 80) send_word();
      else if (sel < 88) begin
        sel = $urandom_range(n - 1);
        send(dwi_pkg::OP_LOAD, 12'(sel), gen_node(sel, n), 0, 0);
      end else if (sel < 94) begin
        send(dwi_pkg::OP_BUILD, 0, 0, 0, 0);
      end else if (sel < 97) begin
        send(OP_UNUSED, 12'($urandom), $urandom, 8'($urandom), 1'($urandom));
      end else begin
        send(dwi_pkg::OP_QUERY, 0, 0, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    board.clear_word();
    board.node_count = 0;
    board.errors = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;

    // Empty table: build takes one pass, any walk fails at once.
    send(dwi_pkg::OP_LOAD, 0, 32'h0000_0001, 0, 0);
    set_nodes(0);
    send(dwi_pkg::OP_BUILD, 0, 0, 0, 0);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h01, 1);
    send(OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 8'hFF, 1);

    // Hand-made table: root -> {01, 02}, 01 -> {03}, 02 -> {FF}.
    set_nodes(6);
    send(dwi_pkg::OP_LOAD, 0, 32'h0000_0001, 0, 0);
    send(dwi_pkg::OP_LOAD, 1, 32'h0180_0003, 0, 0);
    send(dwi_pkg::OP_LOAD, 2, 32'h02C0_0004, 0, 0);
    send(dwi_pkg::OP_LOAD, 3, 32'h03C0_0000, 0, 0);
    send(dwi_pkg::OP_LOAD, 4, 32'hFFFF_FFFF, 0, 0);
    send(dwi_pkg::OP_LOAD, 5, 32'h00C0_0000, 0, 0);
    send(dwi_pkg::OP_BUILD, 0, 0, 0, 0);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h01, 1);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h02, 1);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h01, 0);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h03, 1);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h09, 0);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h01, 0);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h03, 1);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h02, 0);
    send(dwi_pkg::OP_LOAD, 5, 32'h00C0_0000, 0, 0);
    send(dwi_pkg::OP_BUILD, 0, 0, 0, 0);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'hFF, 1);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h03, 0);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h00, 1);

    // Self loop keeps counts growing until the pass cap.
    set_nodes(4);
    send(dwi_pkg::OP_LOAD, 1, 32'h05C0_0001, 0, 0);
    send(dwi_pkg::OP_BUILD, 0, 0, 0, 0);

    while (rand_items < 880) begin
      idle_on = !(rand_items >= 300 && rand_items < 500);
      if ($urandom_range(9) == 0) run_phase($urandom_range(160, 2), 10);
      else run_phase($urandom_range(48, 1), 20);
    end
    idle_on = 1;

    // Close any open word, then check the register past the table size:
    // a root arc beyond the table must fail the walk.
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h00, 1);
    send(dwi_pkg::OP_LOAD, 0, 32'h0000_1388, 0, 0);
    set_nodes(13'h1FFF);
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h01, 1);
    set_nodes(13'(TABLE_DEPTH));
    send(dwi_pkg::OP_QUERY, 0, 0, 8'h01, 1);

    @(negedge clk_i);
    start_i = 0;
    while (board.answers.size() != 0) @(negedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.answers.size() == 0) $display("PASS dawg_word_index_lookup_core");
    else $display("FAIL dawg_word_index_lookup_core");
    $finish;
  end

  initial begin
    #(8 * 20_000_000);
    $display("FAIL dawg_word_index_lookup_core");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dwi_pkg.sv
sv/dwi_alu.sv
sv/dawg_word_index_lookup_core.sv
tb/dawg_word_index_lookup_core_test.sv
